// ===== rtl/core/okle_pkg.sv =====
// Shared constants, codes and types of the ordered keyed list engine.
`default_nettype none
package okle_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 32;
  localparam int OP_W         = 3;
  localparam int STAT_W       = 3;
  localparam int POS_W        = 6;

  localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OP_W-1:0] OP_PREPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
  localparam logic [OP_W-1:0] OP_UPDATE  = 3'd4;
  localparam logic [OP_W-1:0] OP_SHOW    = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_DUP      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_ROT,
    CM_INS,
    CM_DEL,
    CM_UPD
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t         mode;
    logic [POS_W-1:0]   pos;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   value;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/okle_if.sv =====
// Command and result channel interfaces of the ordered keyed list engine.
`default_nettype none
interface okle_in_if;
  import okle_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [KEY_W-1:0]  key;
  logic signed [KEY_W-1:0]  value;
  logic signed [KEY_W-1:0]  anchor_key;

  modport source (output valid, op, key, value, anchor_key, input ready);
  modport sink   (input valid, op, key, value, anchor_key, output ready);
endinterface

interface okle_out_if;
  import okle_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [KEY_W-1:0]  out_key;
  logic signed [KEY_W-1:0]  out_value;
  logic                     last;

  modport source (output valid, status, out_key, out_value, last, input ready);
  modport sink   (input valid, status, out_key, out_value, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/okle_cell.sv =====
// One slot of the list ring: holds a key/data pair and moves it between neighbours.
`default_nettype none
module okle_cell #(
  parameter int IDX = 0
) (
  input  wire                       clk,
  input  okle_pkg::cell_cmd_t       cmd,
  input  wire [okle_pkg::KEY_W-1:0] left_key,
  input  wire [okle_pkg::KEY_W-1:0] left_value,
  input  wire [okle_pkg::KEY_W-1:0] right_key,
  input  wire [okle_pkg::KEY_W-1:0] right_value,
  output logic [okle_pkg::KEY_W-1:0] key_q,
  output logic [okle_pkg::KEY_W-1:0] value_q
);
  import okle_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] value_r, value_nxt;

  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    case (cmd.mode)
      CM_ROT: begin
        key_nxt   = right_key;
        value_nxt = right_value;
      end
      CM_INS: begin
        if (cmd.pos == MY_POS) begin
          key_nxt   = cmd.key;
          value_nxt = cmd.value;
        end else if (MY_POS > cmd.pos) begin
          key_nxt   = left_key;
          value_nxt = left_value;
        end
      end
      CM_DEL: begin
        if (MY_POS >= cmd.pos) begin
          key_nxt   = right_key;
          value_nxt = right_value;
        end
      end
      CM_UPD: begin
        if (cmd.pos == MY_POS) begin
          value_nxt = cmd.value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign key_q   = key_r;
  assign value_q = value_r;

endmodule
`default_nettype wire

// ===== rtl/core/okle_ctrl.sv =====
// Sequencer of the list engine: walks the ring, decides status and edits, drives results.
`default_nettype none
module okle_ctrl #(
  parameter int CAPACITY = okle_pkg::CAPACITY_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  okle_in_if.sink                    in_ch,
  okle_out_if.source                 out_ch,
  input  wire [okle_pkg::KEY_W-1:0]  head_key,
  input  wire [okle_pkg::KEY_W-1:0]  head_value,
  output okle_pkg::cell_cmd_t        cmd
);
  import okle_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] STEP_LAST = IW'(CAPACITY - 1);
  localparam logic [PW-1:0] CNT_FULL  = PW'(CAPACITY);

  ctrl_state_t state_r, state_nxt;

  logic [OP_W-1:0]   op_r;
  logic [KEY_W-1:0]  key_r, value_r, anchor_r;
  logic [IW-1:0]     step_r, step_nxt;
  logic [PW-1:0]     cnt_r, cnt_nxt;
  logic              found_k_r, found_k_nxt, found_a_r, found_a_nxt;
  logic [IW-1:0]     pos_k_r, pos_k_nxt, pos_a_r, pos_a_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [KEY_W-1:0]  out_key_r, out_key_nxt, out_value_r, out_value_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept, out_free, in_range, is_show, walk_adv, show_emit;
  logic              emit_done, done_fire, full;
  logic [STAT_W-1:0] stat_d;
  cell_mode_t        mode_d;
  logic [POS_W-1:0]  pos_d;

  assign accept    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_range  = PW'(step_r) < cnt_r;
  assign is_show   = op_r == OP_SHOW;
  assign full      = cnt_r == CNT_FULL;
  assign walk_adv  = (state_r == S_WALK) && (!(is_show && in_range) || out_free);
  assign show_emit = walk_adv && is_show && in_range;
  assign emit_done = !(is_show && cnt_r != '0);
  assign done_fire = (state_r == S_DONE) && (out_free || !emit_done);

  // status and edit of the finished walk
  always_comb begin
    stat_d = STAT_OK;
    mode_d = CM_HOLD;
    pos_d  = '0;
    case (op_r)
      OP_APPEND, OP_PREPEND: begin
        if (found_k_r) begin
          stat_d = STAT_DUP;
        end else if (full) begin
          stat_d = STAT_FULL;
        end else begin
          mode_d = CM_INS;
          pos_d  = (op_r == OP_APPEND) ? POS_W'(cnt_r) : '0;
        end
      end
      OP_INSERT: begin
        if (!found_a_r) begin
          stat_d = STAT_NOTFOUND;
        end else if (found_k_r) begin
          stat_d = STAT_DUP;
        end else if (full) begin
          stat_d = STAT_FULL;
        end else begin
          mode_d = CM_INS;
          pos_d  = POS_W'(pos_a_r) + POS_W'(1);
        end
      end
      OP_DELETE: begin
        if (!found_k_r) begin
          stat_d = STAT_NOTFOUND;
        end else begin
          mode_d = CM_DEL;
          pos_d  = POS_W'(pos_k_r);
        end
      end
      OP_UPDATE: begin
        if (!found_k_r) begin
          stat_d = STAT_NOTFOUND;
        end else begin
          mode_d = CM_UPD;
          pos_d  = POS_W'(pos_k_r);
        end
      end
      OP_SHOW: begin
        if (cnt_r == '0) begin
          stat_d = STAT_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_adv && step_r == STEP_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    step_nxt       = step_r;
    cnt_nxt        = cnt_r;
    found_k_nxt    = found_k_r;
    found_a_nxt    = found_a_r;
    pos_k_nxt      = pos_k_r;
    pos_a_nxt      = pos_a_r;
    out_valid_nxt  = out_ch.ready ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    cmd.mode       = CM_HOLD;
    cmd.pos        = pos_d;
    cmd.key        = key_r;
    cmd.value      = value_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          step_nxt    = '0;
          found_k_nxt = 1'b0;
          found_a_nxt = 1'b0;
        end
      end
      S_WALK: begin
        if (walk_adv) begin
          cmd.mode = CM_ROT;
          step_nxt = (step_r == STEP_LAST) ? '0 : step_r + IW'(1);
          if (in_range && head_key == key_r) begin
            found_k_nxt = 1'b1;
            pos_k_nxt   = step_r;
          end
          if (in_range && head_key == anchor_r) begin
            found_a_nxt = 1'b1;
            pos_a_nxt   = step_r;
          end
        end
        if (show_emit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_key_nxt    = head_key;
          out_value_nxt  = head_value;
          out_last_nxt   = (PW'(step_r) + PW'(1)) == cnt_r;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          cmd.mode = mode_d;
          if (mode_d == CM_INS) begin
            cnt_nxt = cnt_r + PW'(1);
          end else if (mode_d == CM_DEL) begin
            cnt_nxt = cnt_r - PW'(1);
          end
          if (emit_done) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = stat_d;
            out_key_nxt    = '0;
            out_value_nxt  = '0;
            out_last_nxt   = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      found_k_r   <= 1'b0;
      found_a_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      found_k_r   <= found_k_nxt;
      found_a_r   <= found_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_ch.op;
      key_r    <= in_ch.key;
      value_r  <= in_ch.value;
      anchor_r <= in_ch.anchor_key;
    end
    pos_k_r      <= pos_k_nxt;
    pos_a_r      <= pos_a_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ch.ready      = state_r == S_IDLE;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_key   = out_key_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.last      = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/core/ordered_keyed_list_engine_top.sv =====
// Top level of the ordered keyed list engine: ring of slot cells and its sequencer.
//
//   channel | dir | handshake     | word
//   in_ch   | in  | valid/ready   | op, key, value, anchor_key
//   out_ch  | out | valid/ready   | status, out_key, out_value, last
//
// A command is accepted, then the ring is rotated once past the head cell, where the key
// and anchor comparators sit, and then the edit is applied.
// Show emits one word per entry during the rotation; out_ch stalls hold the rotation.
// Reset clears the entry count and control; slot contents need no clearing.
// in_ch.ready is high only between commands; one result word waits in the output register.
`default_nettype none
module ordered_keyed_list_engine_top #(
  parameter int CAPACITY = okle_pkg::CAPACITY_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  okle_in_if.sink      in_ch,
  okle_out_if.source   out_ch
);
  import okle_pkg::*;

  cell_cmd_t        cmd;
  logic [KEY_W-1:0] cell_key   [CAPACITY];
  logic [KEY_W-1:0] cell_value [CAPACITY];

  okle_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .head_key   (cell_key[0]),
    .head_value (cell_value[0]),
    .cmd        (cmd)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    okle_cell #(
      .IDX (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .left_key    (cell_key[(i + CAPACITY - 1) % CAPACITY]),
      .left_value  (cell_value[(i + CAPACITY - 1) % CAPACITY]),
      .right_key   (cell_key[(i + 1) % CAPACITY]),
      .right_value (cell_value[(i + 1) % CAPACITY]),
      .key_q       (cell_key[i]),
      .value_q     (cell_value[i])
    );
  end

endmodule
`default_nettype wire

// ===== rtl/core/okle_checker.sv =====
// Port-level checks of the ordered keyed list engine, bound to its top level.
`default_nettype none
module okle_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [okle_pkg::STAT_W-1:0]   out_status,
  input wire [okle_pkg::KEY_W-1:0]    out_key,
  input wire [okle_pkg::KEY_W-1:0]    out_value,
  input wire                          out_last
);
  import okle_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_key)
      && $stable(out_value) && $stable(out_last))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while previous one in flight");

  a_status_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_last && out_key == '0 && out_value == '0)
    else $error("status word not final or carries entry data");

  a_non_last_is_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == STAT_OK)
    else $error("non-final word with error status");

endmodule

bind ordered_keyed_list_engine_top okle_checker u_okle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_key    (out_ch.out_key),
  .out_value  (out_ch.out_value),
  .out_last   (out_ch.last)
);
`default_nettype wire
